[hdl/epzi_pkg.sv]
// ----------------------------------------------------------------------------
// epzi_pkg: shared types and constants
// Beat structs, register indexes, operation codes and sequencer states for
// the eased pan/zoom interpolator.
// ----------------------------------------------------------------------------
package epzi_pkg;

	localparam int unsigned PosW  = 32;
	localparam int unsigned ZoomW = 24;
	localparam int unsigned DurW  = 16;
	localparam int unsigned TimeW = 32;
	localparam int unsigned FracW = 16;
	localparam int unsigned MulAW = 34;
	localparam int unsigned MulBW = 18;
	localparam int unsigned MulPW = MulAW + MulBW;

	localparam logic [ZoomW-1:0] ZoomReset = 24'd65536;

	localparam logic [2:0] REG_START_X     = 3'd0;
	localparam logic [2:0] REG_START_Y     = 3'd1;
	localparam logic [2:0] REG_START_ZOOM  = 3'd2;
	localparam logic [2:0] REG_TARGET_X    = 3'd3;
	localparam logic [2:0] REG_TARGET_Y    = 3'd4;
	localparam logic [2:0] REG_TARGET_ZOOM = 3'd5;
	localparam logic [2:0] REG_SMOOTH_MODE = 3'd6;
	localparam logic [2:0] REG_DURATION_MS = 3'd7;

	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;

	typedef struct packed {
		logic [1:0]       operation;
		logic [TimeW-1:0] current_time_ms;
	} epzi_in_t;

	typedef struct packed {
		logic signed [PosW-1:0] out_x;
		logic signed [PosW-1:0] out_y;
		logic [ZoomW-1:0]       out_zoom;
		logic                   written;
		logic                   complete;
	} epzi_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQ,
		ST_CUBE,
		ST_EASE,
		ST_BX,
		ST_BY,
		ST_BZ,
		ST_BZW,
		ST_DONE
	} epzi_state_t;

endpackage

[hdl/eased_pan_zoom_interpolator.sv]
// ----------------------------------------------------------------------------
// eased_pan_zoom_interpolator: cubic ease-in-out pan and zoom
// Moves x, y and zoom from start toward target values, one result beat per
// input beat, using a bit-serial divider and one shared multiplier.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------
//   in      | in_valid / in_stall   | in_data  (operation, current_time_ms)
//   out     | out_valid / out_stall | out_data (x, y, zoom, written, complete)
//   cfg     | cfg_we                | cfg_index, cfg_data
//
// An eased update runs the divide step (16 quotient bits, one a cycle, then
// the done strobe), then the shared multiplier (square, cube, ease, three
// blends, last product), the result hand-off and the return to idle. Start,
// cancel, jump and finishing updates go straight to the result hand-off.
// The input stalls while an item is at work; a finished result waits in the
// output register, and the next beat is taken meanwhile. Reset returns the
// configuration registers and the sequencer to their reset values and
// disarms.
// ----------------------------------------------------------------------------
module eased_pan_zoom_interpolator import epzi_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  epzi_in_t        in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output epzi_out_t       out_data,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [PosW-1:0] cfg_data
);

	// configuration registers
	logic signed [PosW-1:0] start_x_q, start_y_q, target_x_q, target_y_q;
	logic [ZoomW-1:0]       start_zoom_q, target_zoom_q;
	logic                   smooth_mode_q;
	logic [DurW-1:0]        duration_ms_q;

	// transition state
	logic                   armed_q;
	logic [TimeW-1:0]       begin_time_q;

	epzi_state_t            state_q, state_d;
	epzi_out_t              res_q;
	epzi_out_t              out_q;
	logic                   out_valid_q;
	logic                   lt_q;
	logic [FracW:0]         u_q;
	logic [FracW:0]         e_q;

	logic                   accept;
	logic [TimeW-1:0]       elapsed;
	logic                   finish;
	logic                   upd_armed;
	logic                   land_target;
	logic                   go_ease;
	logic                   div_done;
	logic [DurW-1:0]        quotient;
	logic signed [MulAW-1:0] mul_a;
	logic signed [MulBW-1:0] mul_b;
	logic signed [MulPW-1:0] mul_p;
	logic [FracW:0]         cube;
	logic                   out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign elapsed = in_data.current_time_ms - begin_time_q;
	// jump mode, zero duration or time run out: land on the targets
	assign finish  = !smooth_mode_q || (duration_ms_q == '0)
		|| (elapsed >= {{(TimeW-DurW){1'b0}}, duration_ms_q});
	assign upd_armed   = accept && (in_data.operation == OP_UPDATE) && armed_q;
	assign land_target = upd_armed && finish;
	assign go_ease     = upd_armed && !finish;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q     <= '0;
			start_y_q     <= '0;
			start_zoom_q  <= ZoomReset;
			target_x_q    <= '0;
			target_y_q    <= '0;
			target_zoom_q <= ZoomReset;
			smooth_mode_q <= 1'b0;
			duration_ms_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_X:     start_x_q     <= cfg_data;
				REG_START_Y:     start_y_q     <= cfg_data;
				REG_START_ZOOM:  start_zoom_q  <= cfg_data[ZoomW-1:0];
				REG_TARGET_X:    target_x_q    <= cfg_data;
				REG_TARGET_Y:    target_y_q    <= cfg_data;
				REG_TARGET_ZOOM: target_zoom_q <= cfg_data[ZoomW-1:0];
				REG_SMOOTH_MODE: smooth_mode_q <= cfg_data[0];
				REG_DURATION_MS: duration_ms_q <= cfg_data[DurW-1:0];
				default: ;
			endcase
		end
	end

	// arm, restart and disarm on accepted beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			begin_time_q <= '0;
		end else if (accept) begin
			case (in_data.operation)
				OP_START: begin
					armed_q      <= 1'b1;
					begin_time_q <= in_data.current_time_ms;
				end
				OP_CANCEL: armed_q <= 1'b0;
				OP_UPDATE: if (armed_q && finish) armed_q <= 1'b0;
				default: ;
			endcase
		end
	end

	epzi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_ease),
		.dividend (elapsed[DurW-1:0]),
		.divisor  (duration_ms_q),
		.done     (div_done),
		.quotient (quotient)
	);

	epzi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// u^3 / 2^30 covers both halves of the curve (u is t or 1 - t)
	assign cube = mul_p[FracW+30:30];

	// sequencer: state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// sequencer: next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (go_ease)     state_d = ST_DIV;
				else if (accept) state_d = ST_DONE;
			end
			ST_DIV:  if (div_done) state_d = ST_SQ;
			ST_SQ: begin
				mul_a   = MulAW'(u_q);
				mul_b   = MulBW'(u_q);
				state_d = ST_CUBE;
			end
			ST_CUBE: begin
				mul_a   = mul_p[MulAW-1:0];
				mul_b   = MulBW'(u_q);
				state_d = ST_EASE;
			end
			ST_EASE: state_d = ST_BX;
			ST_BX: begin
				mul_a   = MulAW'(target_x_q) - MulAW'(start_x_q);
				mul_b   = MulBW'(e_q);
				state_d = ST_BY;
			end
			ST_BY: begin
				mul_a   = MulAW'(target_y_q) - MulAW'(start_y_q);
				mul_b   = MulBW'(e_q);
				state_d = ST_BZ;
			end
			ST_BZ: begin
				mul_a   = MulAW'(target_zoom_q) - MulAW'(start_zoom_q);
				mul_b   = MulBW'(e_q);
				state_d = ST_BZW;
			end
			ST_BZW:  state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// result assembly
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				res_q.written  <= upd_armed;
				res_q.complete <= land_target;
				res_q.out_x    <= land_target ? target_x_q : '0;
				res_q.out_y    <= land_target ? target_y_q : '0;
				res_q.out_zoom <= land_target ? target_zoom_q : '0;
			end
			ST_DIV: if (div_done) begin
				// fold the upper half onto 1 - t
				lt_q <= ~quotient[DurW-1];
				u_q  <= quotient[DurW-1] ? ((FracW+1)'(1 << FracW) - {1'b0, quotient})
				                         : {1'b0, quotient};
			end
			ST_EASE: e_q <= lt_q ? cube : ((FracW+1)'(1 << FracW) - cube);
			ST_BY:   res_q.out_x    <= start_x_q + mul_p[PosW+FracW-1:FracW];
			ST_BZ:   res_q.out_y    <= start_y_q + mul_p[PosW+FracW-1:FracW];
			ST_BZW:  res_q.out_zoom <= start_zoom_q + mul_p[ZoomW+FracW-1:FracW];
			default: ;
		endcase
	end

	// output register: hold until taken, load from the finished result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("input taken while an item is at work");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide step");

	a_complete_written: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.complete |-> out_data.written)
		else $error("completion flagged on an unwritten result");

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.written |->
			out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_zoom == '0)
		else $error("unwritten result carries data");

	a_ease_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		go_ease |=> armed_q)
		else $error("eased update disarmed the transition");

endmodule

[hdl/epzi_div.sv]
// ----------------------------------------------------------------------------
// epzi_div: restoring fraction divider
// Produces floor(dividend * 2^16 / divisor) for dividend < divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module epzi_div import epzi_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DurW-1:0] dividend,
	input  logic [DurW-1:0] divisor,
	output logic            done,
	output logic [DurW-1:0] quotient
);

	logic [DurW-1:0]          rem_q;
	logic [DurW-1:0]          quo_q;
	logic [DurW-1:0]          dsr_q;
	logic [$clog2(DurW)-1:0]  cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [DurW:0]            shifted;
	logic [DurW:0]            trial;
	logic                     qbit;
	logic                     last_bit;

	assign shifted  = {rem_q, 1'b0};
	assign trial    = shifted - {1'b0, dsr_q};
	assign qbit     = ~trial[DurW];
	assign last_bit = (cnt_q == $clog2(DurW)'(DurW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && last_bit;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// payload: remainder, quotient and divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[DurW-1:0] : shifted[DurW-1:0];
			quo_q <= {quo_q[DurW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/epzi_mul.sv]
// ----------------------------------------------------------------------------
// epzi_mul: shared signed multiplier
// One registered signed product, reused for the square, the cube and the three blends.
// ----------------------------------------------------------------------------
module epzi_mul import epzi_pkg::*; (
	input  logic                    clk,
	input  logic signed [MulAW-1:0] a,
	input  logic signed [MulBW-1:0] b,
	output logic signed [MulPW-1:0] p
);

	logic signed [MulPW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MulPW'(a) * MulPW'(b);
	end

	assign p = p_q;

endmodule
